[src/slfl_pkg.sv]
package slfl_pkg;

    localparam int NUM_INDEXES_DEF     = 16;
    localparam int ENTRIES_PER_MAP_DEF = 64;
    localparam int NUM_FAMILIES        = 4;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_CLEAR_IDX = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNREACHED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        positional;
        logic        z_side;
        logic [3:0]  index_number;
        logic [31:0] term_key;
        logic [63:0] entry_offset;
    } cmd_t;

    typedef struct packed {
        logic [63:0] found_offset;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

[src/sparse_lexicon_floor_lookup.sv]
// Sparse lexicon floor lookup: four families of small ordered maps from
// 32-bit term keys to 64-bit offsets, one map per index number.
// A transaction is taken at a clock edge with start high and busy low.
// busy stays high until the result, which appears on result for exactly
// one cycle with done high; the receiver cannot stall it.
// The fill count of the addressed map is read from the count memory in
// the cycle after the transaction is taken. Insert and floor lookup then
// scan the held entries of one map through the single entry memory read
// port, one entry per cycle, so the busy time grows with the fill count
// of the map. Clears, unreached or empty lookups and inserts with an
// index out of range scan no entries. busy drops in the done cycle, so
// the next transaction can be taken at the edge that ends it.
// Reset clears the count valid flags and family extents at once; neither
// memory needs clearing since a count is only used while its flag is set
// and only entries below a fill count are ever read.
module sparse_lexicon_floor_lookup #(
    parameter int NUM_INDEXES     = slfl_pkg::NUM_INDEXES_DEF,
    parameter int ENTRIES_PER_MAP = slfl_pkg::ENTRIES_PER_MAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slfl_pkg::cmd_t    cmd,
    output logic              done,
    output slfl_pkg::result_t result
);
    import slfl_pkg::*;

    localparam int NUM_MAPS = NUM_FAMILIES * NUM_INDEXES;
    localparam int MW       = $clog2(NUM_MAPS);
    localparam int EW       = (ENTRIES_PER_MAP > 1) ? $clog2(ENTRIES_PER_MAP) : 1;
    localparam int CW       = $clog2(ENTRIES_PER_MAP + 1);
    localparam int AW       = MW + EW;
    localparam int XW       = $clog2(NUM_INDEXES + 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [CW-1:0] cnt_mem [NUM_MAPS];
    logic [CW-1:0] cnt_rd_reg;
    logic [NUM_MAPS-1:0] cnt_vld_reg;
    logic [XW-1:0] ext_reg [NUM_FAMILIES];
    logic [CW-1:0] n_reg, i_reg;
    logic [MW-1:0] map_reg;
    logic          have_floor_reg, dup_reg;
    logic [31:0]   floor_key_reg, min_key_reg;
    logic [63:0]   floor_off_reg, min_off_reg;
    result_t       res_reg;
    logic          done_reg;

    logic [1:0]    fam;
    logic          idx_ok;
    logic [MW-1:0] map_c;
    logic [CW-1:0] cnt_cur;
    logic [31:0]   rkey;
    logic [63:0]   roff;
    logic          we;
    logic [AW-1:0] raddr, waddr;
    logic          rd_valid_reg;
    logic [CW-1:0] rd_pos_reg;

    assign fam    = {cmd.positional, cmd.z_side};
    assign idx_ok = 32'(cmd.index_number) < NUM_INDEXES;
    assign map_c  = MW'(32'(fam) * NUM_INDEXES + 32'(cmd.index_number));
    assign cnt_cur = cnt_vld_reg[map_reg] ? cnt_rd_reg : '0;
    assign raddr  = {map_reg, i_reg[EW-1:0]};
    assign waddr  = {map_reg, n_reg[EW-1:0]};
    assign we     = (state_reg == S_WRITE) && !dup_reg && (32'(n_reg) < ENTRIES_PER_MAP)
                    && (cmd_reg.operation == OP_INSERT);

    slfl_entry_ram #(.DEPTH(1 << AW), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wkey(cmd_reg.term_key),
        .woff(cmd_reg.entry_offset), .raddr(raddr), .rkey(rkey), .roff(roff)
    );

    // The fill count is read at the accepting edge and written back after an insert.
    always_ff @(posedge clk)
    begin
        if (we)
            cnt_mem[map_reg] <= n_reg + CW'(1);
        cnt_rd_reg <= cnt_mem[map_c];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_FETCH;
            S_FETCH: state_next = S_SCAN;
            S_SCAN:  if (i_reg >= n_reg) state_next = S_LAST;
            S_LAST:  state_next = S_WRITE;
            S_WRITE: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            cnt_vld_reg  <= '0;
            for (int f = 0; f < NUM_FAMILIES; f++) ext_reg[f] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= 1'b0;
            rd_valid_reg <= (state_reg == S_SCAN) && (i_reg < n_reg);
            if (state_reg == S_IDLE && start)
            begin
                // Non-scanning operations are resolved here with n = 0.
                cmd_reg        <= cmd;
                map_reg        <= map_c;
                i_reg          <= '0;
                have_floor_reg <= 1'b0;
                dup_reg        <= 1'b0;
                n_reg          <= '0;
                res_reg        <= '{found_offset: '0, status: ST_OK};
                unique case (op_t'(cmd.operation))
                    OP_INSERT:
                    begin
                        if (!idx_ok)
                        begin
                            res_reg.status <= ST_FULL;
                            dup_reg        <= 1'b1;
                        end
                        else
                        begin
                            if (ext_reg[fam] < XW'(cmd.index_number) + XW'(1))
                                ext_reg[fam] <= XW'(cmd.index_number) + XW'(1);
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (!idx_ok || XW'(cmd.index_number) >= ext_reg[fam])
                            res_reg.status <= ST_UNREACHED;
                    end
                    OP_CLEAR_IDX:
                    begin
                        if (idx_ok)
                        begin
                            cnt_vld_reg[MW'(32'({cmd.positional, 1'b0}) * NUM_INDEXES
                                + 32'(cmd.index_number))] <= 1'b0;
                            cnt_vld_reg[MW'(32'({cmd.positional, 1'b1}) * NUM_INDEXES
                                + 32'(cmd.index_number))] <= 1'b0;
                        end
                    end
                    OP_CLEAR_ALL:
                    begin
                        cnt_vld_reg <= '0;
                        for (int f = 0; f < NUM_FAMILIES; f++) ext_reg[f] <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_FETCH && res_reg.status == ST_OK)
            begin
                if (cmd_reg.operation == OP_INSERT)
                    n_reg <= cnt_cur;
                else if (cmd_reg.operation == OP_LOOKUP)
                begin
                    if (cnt_cur == '0)
                        res_reg.status <= ST_EMPTY;
                    else
                        n_reg <= cnt_cur;
                end
            end
            if (state_reg == S_SCAN && i_reg < n_reg)
            begin
                i_reg <= i_reg + CW'(1);
                rd_pos_reg <= i_reg;
            end
            if (rd_valid_reg)
            begin
                if (rkey == cmd_reg.term_key) dup_reg <= 1'b1;
                if (rd_pos_reg == '0 || rkey < min_key_reg)
                begin
                    min_key_reg <= rkey;
                    min_off_reg <= roff;
                end
                if (rkey <= cmd_reg.term_key && (!have_floor_reg || rkey > floor_key_reg))
                begin
                    have_floor_reg <= 1'b1;
                    floor_key_reg  <= rkey;
                    floor_off_reg  <= roff;
                end
            end
            if (state_reg == S_WRITE && n_reg != '0 || we)
            begin
                if (cmd_reg.operation == OP_LOOKUP)
                    res_reg.found_offset <= have_floor_reg ? floor_off_reg : min_off_reg;
                else if (!dup_reg && 32'(n_reg) >= ENTRIES_PER_MAP)
                    res_reg.status <= ST_FULL;
            end
            if (state_reg == S_WRITE && cmd_reg.operation == OP_INSERT && !dup_reg
                && 32'(n_reg) >= ENTRIES_PER_MAP)
                res_reg.status <= ST_FULL;
            if (we)
                cnt_vld_reg[map_reg] <= 1'b1;
            if (state_reg == S_DONE)
                done_reg <= 1'b1;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE) else $error("stray result");
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.found_offset == '0)
        else $error("offset with error status");
endmodule

[src/slfl_entry_ram.sv]
module slfl_entry_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wkey,
    input  logic [63:0]   woff,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rkey,
    output logic [63:0]   roff
);
    logic [31:0] key_mem [DEPTH];
    logic [63:0] off_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            off_mem[waddr] <= woff;
        end
        rkey <= key_mem[raddr];
        roff <= off_mem[raddr];
    end
endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slfl_pkg::*;

    localparam int NIDX = NUM_INDEXES_DEF;
    localparam int NENT = ENTRIES_PER_MAP_DEF;

    // Behavioral copy of the four map families, with the expected results in order.
    class lexicon_scoreboard;
        logic [31:0] keys [4][NIDX][NENT];
        logic [63:0] offs [4][NIDX][NENT];
        int          fill [4][NIDX];
        int          extent [4];
        result_t     pending [$];
        int          errors;

        function new();
            errors = 0;
            foreach (fill[f, i]) fill[f][i] = 0;
            foreach (extent[f]) extent[f] = 0;
        endfunction

        function void note_command(cmd_t c);
            result_t r;
            int fam;
            int idx;
            int n;
            bit dup;
            bit have;
            logic [31:0] fk;
            logic [31:0] mk;
            logic [63:0] fo;
            logic [63:0] mo;
            fam = int'({c.positional, c.z_side});
            idx = int'(c.index_number);
            r.found_offset = '0;
            r.status = ST_OK;
            case (op_t'(c.operation))
                OP_INSERT: begin
                    if (extent[fam] < idx + 1) extent[fam] = idx + 1;
                    n = fill[fam][idx];
                    dup = 0;
                    for (int i = 0; i < n; i++)
                        if (keys[fam][idx][i] == c.term_key) dup = 1;
                    if (!dup) begin
                        if (n >= NENT) r.status = ST_FULL;
                        else
                        begin
                            keys[fam][idx][n] = c.term_key;
                            offs[fam][idx][n] = c.entry_offset;
                            fill[fam][idx] = n + 1;
                        end
                    end
                end
                OP_LOOKUP: begin
                    n = fill[fam][idx];
                    if (idx >= extent[fam]) r.status = ST_UNREACHED;
                    else if (n == 0) r.status = ST_EMPTY;
                    else
                    begin
                        have = 0;
                        fk = '0; mk = '0; fo = '0; mo = '0;
                        for (int i = 0; i < n; i++) begin
                            if (i == 0 || keys[fam][idx][i] < mk) begin
                                mk = keys[fam][idx][i];
                                mo = offs[fam][idx][i];
                            end
                            if (keys[fam][idx][i] <= c.term_key
                                && (!have || keys[fam][idx][i] > fk)) begin
                                have = 1;
                                fk = keys[fam][idx][i];
                                fo = offs[fam][idx][i];
                            end
                        end
                        r.found_offset = have ? fo : mo;
                    end
                end
                OP_CLEAR_IDX: begin
                    fill[{c.positional, 1'b0}][idx] = 0;
                    fill[{c.positional, 1'b1}][idx] = 0;
                end
                default: begin
                    foreach (fill[f, i]) fill[f][i] = 0;
                    foreach (extent[f]) extent[f] = 0;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0) begin
                $error("unexpected result: found_offset %h status %0d",
                       got.found_offset, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.found_offset !== exp.found_offset) begin
                $error("found_offset: expected %h, actual %h",
                       exp.found_offset, got.found_offset);
                errors++;
            end
        endfunction
    endclass

    logic    clk = 0;
    logic    rst_n = 0;
    logic    start = 0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    lexicon_scoreboard sb = new();
    logic [31:0] key_pool [8];

    sparse_lexicon_floor_lookup u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && done) sb.check_result(result);
    end

    // Holds start until the transaction is taken; start stays high for back-to-back commands.
    task automatic issue(input cmd_t c, input bit keep);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        sb.note_command(c);
        if (!keep)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic cmd_t make_cmd(input op_t op, input bit p, input bit z,
                                      input int idx, input logic [31:0] k,
                                      input logic [63:0] o);
        cmd_t c;
        c.operation = op;
        c.positional = p;
        c.z_side = z;
        c.index_number = 4'(idx);
        c.term_key = k;
        c.entry_offset = o;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.positional = 1'($urandom);
        c.z_side = 1'($urandom);
        // Keep most traffic on a few indexes so maps fill and lookups hit.
        c.index_number = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 2));
        c.term_key = ($urandom_range(0, 2) == 0) ? 32'($urandom)
                     : key_pool[$urandom_range(0, 7)] + 32'($urandom_range(0, 2)) - 32'd1;
        c.entry_offset = {$urandom, $urandom};
        if (r < 50) c.operation = OP_INSERT;
        else if (r < 94) c.operation = OP_LOOKUP;
        else if (r < 99) c.operation = OP_CLEAR_IDX;
        else c.operation = OP_CLEAR_ALL;
        return c;
    endfunction

    initial begin
        int sent;
        int burst;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unreached, empty, extremes, duplicate, floor below all keys, full map, clears.
        issue(make_cmd(OP_LOOKUP, 0, 0, 0, 32'h0, 64'h0), 0);
        issue(make_cmd(OP_INSERT, 1, 1, 15, 32'hFFFF_FFFF, '1), 1);
        issue(make_cmd(OP_LOOKUP, 1, 1, 15, 32'h0, 64'h0), 1);
        issue(make_cmd(OP_LOOKUP, 1, 1, 3, 32'h0, 64'h0), 0);
        issue(make_cmd(OP_INSERT, 1, 1, 15, 32'hFFFF_FFFF, 64'h1234), 0);
        issue(make_cmd(OP_INSERT, 1, 1, 15, 32'h0, 64'h5555_AAAA_5555_AAAA), 0);
        issue(make_cmd(OP_INSERT, 1, 1, 15, 32'h8000_0000, 64'hAAAA_5555_AAAA_5555), 1);
        issue(make_cmd(OP_LOOKUP, 1, 1, 15, 32'h7FFF_FFFF, 64'h0), 1);
        issue(make_cmd(OP_LOOKUP, 1, 1, 15, 32'hFFFF_FFFF, 64'h0), 0);
        issue(make_cmd(OP_INSERT, 1, 0, 15, 32'h10, 64'h1), 0);
        issue(make_cmd(OP_CLEAR_IDX, 1, 0, 15, 32'h0, 64'h0), 0);
        issue(make_cmd(OP_LOOKUP, 1, 1, 15, 32'h0, 64'h0), 0);
        issue(make_cmd(OP_LOOKUP, 1, 0, 15, 32'h0, 64'h0), 0);
        for (int i = 0; i < NENT + 1; i++)
            issue(make_cmd(OP_INSERT, 0, 1, 2, 32'd100 + i, 64'd7 * i), 1);
        issue(make_cmd(OP_LOOKUP, 0, 1, 2, 32'd99, 64'h0), 1);
        issue(make_cmd(OP_LOOKUP, 0, 1, 2, 32'd130, 64'h0), 0);
        issue(make_cmd(OP_CLEAR_ALL, 0, 0, 0, 32'h0, 64'h0), 0);
        issue(make_cmd(OP_LOOKUP, 0, 1, 2, 32'd130, 64'h0), 0);

        sent = 0;
        while (sent < 770) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                issue(random_cmd(), b != burst - 1);
                sent++;
            end
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (NENT + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
